/* rtl/lop_pkg.sv */
// Shared types and constants for the lexicographic ordering bounds propagator.
// Holds value widths, vector limits, status and phase codes and the stage structs.
// No dependencies.
package lop_pkg;

  localparam int MaxLen       = 64;
  localparam int ValueWidth   = 32;
  localparam int CountWidth   = $clog2(MaxLen + 1);
  localparam int CfgAddrWidth = 2;

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic signed [ValueWidth:0]   wide_t;
  typedef logic [CountWidth-1:0]        count_t;
  typedef logic [CfgAddrWidth-1:0]      cfg_addr_t;

  localparam cfg_addr_t CFG_ALLOW_EQ    = 2'd0;
  localparam cfg_addr_t CFG_NEGATED     = 2'd1;
  localparam cfg_addr_t CFG_DETECT_ONLY = 2'd2;

  typedef enum logic [2:0] {
    ST_ACTIVE    = 3'd0,
    ST_ENTAILED  = 3'd1,
    ST_FAILED    = 3'd2,
    ST_HOLDS     = 3'd3,
    ST_NOT_HOLD  = 3'd4,
    ST_UNDECIDED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_SEEK = 3'b001,
    PH_SCAN = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  // One position, already oriented: a is the greater side, b the lesser side.
  typedef struct packed {
    value_t alo;
    value_t ahi;
    value_t blo;
    value_t bhi;
    logic   last;
  } item_t;

  // Scan summary handed to the resolver at the end of a vector.
  typedef struct packed {
    logic   found;
    count_t pidx;
    value_t lo1;
    value_t hi1;
    value_t lo2;
    value_t hi2;
    logic   beta;
    logic   blocked;
  } scan_sum_t;

  typedef struct packed {
    status_t status;
    count_t  pidx;
    value_t  lo;
    value_t  hi;
  } result_t;

endpackage

/* rtl/lop_scan.sv */
// Running scan state of the propagator: pivot search and look-ahead past the pivot.
// Depends on lop_pkg.
module lop_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  lop_pkg::item_t    item,
  output logic              end_now,
  output lop_pkg::scan_sum_t sum
);
  import lop_pkg::*;

  phase_t phase_r, phase_nxt;
  count_t count_r;
  count_t piv_pos_r, piv_pos_nxt;
  value_t lo1_r, hi1_r, lo2_r, hi2_r;
  value_t lo1_nxt, hi1_nxt, lo2_nxt, hi2_nxt;
  logic   beta_r, beta_nxt;
  logic   blocked_r, blocked_nxt;
  logic   fixed_eq;

  assign fixed_eq = (item.alo == item.ahi) && (item.blo == item.bhi) && (item.alo == item.blo);
  assign end_now  = item.last || (count_r == count_t'(MaxLen - 1));

  always_comb begin
    phase_nxt   = phase_r;
    piv_pos_nxt = piv_pos_r;
    lo1_nxt     = lo1_r;
    hi1_nxt     = hi1_r;
    lo2_nxt     = lo2_r;
    hi2_nxt     = hi2_r;
    beta_nxt    = beta_r;
    blocked_nxt = blocked_r;
    case (phase_r)
      PH_SEEK: begin
        if (!fixed_eq) begin
          piv_pos_nxt = count_r;
          lo1_nxt     = item.alo;
          hi1_nxt     = item.ahi;
          lo2_nxt     = item.blo;
          hi2_nxt     = item.bhi;
          phase_nxt   = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if (item.ahi > item.blo) begin
          beta_nxt  = 1'b1;
          phase_nxt = PH_DONE;
        end else if (item.ahi < item.blo) begin
          blocked_nxt = 1'b1;
          phase_nxt   = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sum.found   = (phase_nxt != PH_SEEK);
    sum.pidx    = sum.found ? piv_pos_nxt : count_r + count_t'(1);
    sum.lo1     = lo1_nxt;
    sum.hi1     = hi1_nxt;
    sum.lo2     = lo2_nxt;
    sum.hi2     = hi2_nxt;
    sum.beta    = beta_nxt;
    sum.blocked = blocked_nxt;
  end

  // Clear the phase, count, pivot index and flags on reset and after the last position; otherwise advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SEEK;
      count_r   <= '0;
      piv_pos_r <= '0;
      beta_r    <= 1'b0;
      blocked_r <= 1'b0;
    end else if (en) begin
      if (end_now) begin
        phase_r   <= PH_SEEK;
        count_r   <= '0;
        piv_pos_r <= '0;
        beta_r    <= 1'b0;
        blocked_r <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        count_r   <= count_r + count_t'(1);
        piv_pos_r <= piv_pos_nxt;
        beta_r    <= beta_nxt;
        blocked_r <= blocked_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo1_r <= lo1_nxt;
      hi1_r <= hi1_nxt;
      lo2_r <= lo2_nxt;
      hi2_r <= hi2_nxt;
    end
  end

endmodule

/* rtl/lop_resolve.sv */
// Final classification and bound tightening at the pivot for one vector pair.
// Depends on lop_pkg.
module lop_resolve (
  input  lop_pkg::scan_sum_t sum,
  input  logic               oe,
  input  logic               detect,
  output lop_pkg::result_t   res
);
  import lop_pkg::*;

  value_t n1lo, n2hi;
  wide_t  lo2p1, hi1m1, f1lo, f2hi;

  assign n1lo  = (sum.lo1 > sum.lo2) ? sum.lo1 : sum.lo2;
  assign n2hi  = (sum.hi2 < sum.hi1) ? sum.hi2 : sum.hi1;
  assign lo2p1 = $signed({sum.lo2[ValueWidth-1], sum.lo2}) + wide_t'(1);
  assign hi1m1 = $signed({sum.hi1[ValueWidth-1], sum.hi1}) - wide_t'(1);
  assign f1lo  = ($signed({n1lo[ValueWidth-1], n1lo}) > lo2p1) ?
                 $signed({n1lo[ValueWidth-1], n1lo}) : lo2p1;
  assign f2hi  = ($signed({n2hi[ValueWidth-1], n2hi}) < hi1m1) ?
                 $signed({n2hi[ValueWidth-1], n2hi}) : hi1m1;

  always_comb begin
    res.pidx   = sum.pidx;
    res.lo     = '0;
    res.hi     = '0;
    res.status = ST_ACTIVE;
    if (!sum.found) begin
      // All positions fixed equal.
      if (detect) res.status = oe ? ST_HOLDS : ST_NOT_HOLD;
      else        res.status = oe ? ST_ENTAILED : ST_FAILED;
    end else begin
      res.lo = sum.lo1;
      res.hi = sum.hi2;
      if (detect) begin
        if (sum.lo1 > sum.hi2)      res.status = ST_HOLDS;
        else if (sum.hi1 < sum.lo2) res.status = ST_NOT_HOLD;
        else                        res.status = ST_UNDECIDED;
      end else if (sum.hi1 < sum.lo2 || sum.lo1 > sum.hi1 || sum.lo2 > sum.hi2) begin
        res.status = ST_FAILED;
      end else if (n1lo > n2hi) begin
        res.status = ST_ENTAILED;
        res.lo     = n1lo;
        res.hi     = n2hi;
      end else if (sum.beta || (oe && !sum.blocked)) begin
        res.status = ST_ACTIVE;
        res.lo     = n1lo;
        res.hi     = n2hi;
      end else if (!(sum.hi1 > sum.lo2)) begin
        res.status = ST_FAILED;
      end else begin
        // Force strict order at the pivot.
        res.status = (f1lo > f2hi) ? ST_ENTAILED : ST_ACTIVE;
        res.lo     = f1lo[ValueWidth-1:0];
        res.hi     = f2hi[ValueWidth-1:0];
      end
    end
  end

endmodule

/* rtl/lex_order_bounds_propagator.sv */
// Top level of the lexicographic ordering bounds propagator.
// Depends on lop_pkg, lop_scan and lop_resolve.
//
// Usage: stream the two vectors one position per transfer on the in_ channel,
// lower and upper bounds of both vectors in in_tdata, in_tlast on the final
// position (position MAX_LEN-1 always closes the vector). One result transfer
// leaves on the out_ channel for each vector, carrying the status in out_tuser
// and the pivot index and tightened pivot bounds in out_tdata.
// The closing position passes from the input register into the result
// register, which drives out_tvalid. Throughput: one position per cycle while
// the input register is not held; the only loop is the small scan state
// updated once per position, and the final resolve is a few 33-bit compares.
// The input register keeps taking positions that close no vector while a
// result waits; a closing position holds in the input register until the
// result register is free, so a stalled receiver stalls the input only then.
// Configuration (allow-equal, negated, detect-only) is written on the cfg_ port
// while the block is idle; each position captures the settings in force when
// it is transferred. Reset (rst_n low, synchronous) empties both registers,
// restarts the scan at position zero, allows equal vectors and clears
// negated and detect-only.
module lex_order_bounds_propagator (
  input  logic                         clk,
  input  logic                         rst_n,
  // lo_first [31:0], hi_first [63:32], lo_second [95:64], hi_second [127:96]
  input  logic [4*lop_pkg::ValueWidth-1:0] in_tdata,
  input  logic                         in_tlast,   // last_position
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // pivot_index [6:0], pivot_new_lo_greater [38:7], pivot_new_hi_lesser [70:39],
  // zero fill [71]
  output logic [71:0]                  out_tdata,
  output logic [2:0]                   out_tuser,  // status
  output logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic                         cfg_we,
  input  lop_pkg::cfg_addr_t           cfg_addr,
  input  logic                         cfg_wdata
);
  import lop_pkg::*;

  localparam int VW = ValueWidth;

  logic      allow_eq_r, negated_r, detect_only_r;
  logic      s1_valid_r, s1_oe_r, s1_det_r;
  item_t     s1_item_r, s1_item_nxt;
  logic      out_valid_r;
  result_t   out_res_r;
  logic      s1_end, s1_adv, scan_en;
  scan_sum_t sum;
  result_t   res;
  value_t    f_alo, f_ahi, f_blo, f_bhi;

  // Configuration registers; writes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_eq_r    <= 1'b1;
      negated_r     <= 1'b0;
      detect_only_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ALLOW_EQ:    allow_eq_r    <= cfg_wdata;
        CFG_NEGATED:     negated_r     <= cfg_wdata;
        CFG_DETECT_ONLY: detect_only_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign f_alo = in_tdata[VW-1:0];
  assign f_ahi = in_tdata[2*VW-1:VW];
  assign f_blo = in_tdata[3*VW-1:2*VW];
  assign f_bhi = in_tdata[4*VW-1:3*VW];

  // Orient on capture: with negation the second vector is the greater side.
  always_comb begin
    s1_item_nxt.last = in_tlast;
    if (negated_r) begin
      s1_item_nxt.alo = f_blo;
      s1_item_nxt.ahi = f_bhi;
      s1_item_nxt.blo = f_alo;
      s1_item_nxt.bhi = f_ahi;
    end else begin
      s1_item_nxt.alo = f_alo;
      s1_item_nxt.ahi = f_ahi;
      s1_item_nxt.blo = f_blo;
      s1_item_nxt.bhi = f_bhi;
    end
  end

  // Advance the input register unless it holds a closing position and the
  // result register is still occupied.
  assign s1_adv    = !s1_end || !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign scan_en   = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= s1_item_nxt;
      s1_oe_r   <= allow_eq_r ^ negated_r;
      s1_det_r  <= detect_only_r;
    end
  end

  lop_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (scan_en),
    .item    (s1_item_r),
    .end_now (s1_end),
    .sum     (sum)
  );

  lop_resolve u_resolve (
    .sum    (sum),
    .oe     (s1_oe_r),
    .detect (s1_det_r),
    .res    (res)
  );

  // Result register: load on a closing position, drop once transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (scan_en && s1_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_en && s1_end) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0, out_res_r.hi, out_res_r.lo, out_res_r.pidx};

endmodule

/* tb/tb_lex_order_bounds_propagator.sv */
// Self-checking testbench for lex_order_bounds_propagator: streams vector positions,
// predicts each vector's verdict and pivot bounds, compares every result transfer.
// Depends on lop_pkg and the lex_order_bounds_propagator RTL.
module tb_lex_order_bounds_propagator;
  timeunit 1ns;
  timeprecision 1ps;

  import lop_pkg::*;

  localparam value_t VMIN = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam value_t VMAX = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam int SETTLE_CYCLES  = 4;     // settle margin after the last owed verdict
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int STALL_LIMIT    = 2000;  // cycles without any transfer
  localparam int PHASE_POSITIONS = 82;

  // One directed stimulus row; want is used only where typed is set.
  typedef struct {
    bit      wr_cfg;
    bit      oe;
    bit      neg;
    bit      det;
    value_t  alo;
    value_t  ahi;
    value_t  blo;
    value_t  bhi;
    bit      last;
    bit      typed;
    result_t want;
  } directed_row_t;

  logic                       clk;
  logic                       rst_n;
  logic [4*ValueWidth-1:0]    in_tdata;
  logic                       in_tlast;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [71:0]                out_tdata;
  logic [2:0]                 out_tuser;
  logic                       out_tvalid;
  logic                       out_tready;
  logic                       cfg_we;
  cfg_addr_t                  cfg_addr;
  logic                       cfg_wdata;

  lex_order_bounds_propagator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Verdicts still owed by the block, oldest first
  result_t expected_verdicts[$];
  directed_row_t directed_rows[$];
  int  mismatches;
  int  sent_positions;
  int  burst_left;
  int  quiet_cycles;
  bit  hold_off_req;

  // Mirror of the configuration registers
  bit reg_allow_eq;
  bit reg_negated;
  bit reg_detect;

  // Mirror of the running scan over the current vector (oriented greater/lesser)
  phase_t scan_state;
  int     pos_count;
  count_t pivot_at;
  longint piv_glo, piv_ghi, piv_llo, piv_lhi;
  bit     free_seen;
  bit     blocking_seen;

  task automatic clear_scan();
    scan_state    = PH_SEEK;
    pos_count     = 0;
    pivot_at      = '0;
    piv_glo       = 0;
    piv_ghi       = 0;
    piv_llo       = 0;
    piv_lhi       = 0;
    free_seen     = 1'b0;
    blocking_seen = 1'b0;
  endtask

  // Advance the scan by one position; on a closing position work out the verdict
  // and the tightened pivot bounds, then restart the scan.
  task automatic propagate_position(input value_t f_lo, input value_t f_hi,
                                    input value_t s_lo, input value_t s_hi,
                                    input bit mark, output bit produced,
                                    output result_t res);
    longint  glo, ghi, llo, lhi;
    longint  n_lo, n_hi, s_lo_f, s_hi_f, out_lo, out_hi;
    bit      eff_oe;
    status_t st;
    eff_oe   = reg_allow_eq ^ reg_negated;
    produced = 1'b0;
    res      = '0;
    // negation makes the second vector the greater side
    if (reg_negated) begin
      glo = s_lo; ghi = s_hi; llo = f_lo; lhi = f_hi;
    end else begin
      glo = f_lo; ghi = f_hi; llo = s_lo; lhi = s_hi;
    end
    case (scan_state)
      PH_SEEK: begin
        if (!(glo == ghi && llo == lhi && glo == llo)) begin
          pivot_at   = count_t'(pos_count);
          piv_glo    = glo;
          piv_ghi    = ghi;
          piv_llo    = llo;
          piv_lhi    = lhi;
          scan_state = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if (ghi > llo) begin
          free_seen  = 1'b1;
          scan_state = PH_DONE;
        end else if (ghi < llo) begin
          blocking_seen = 1'b1;
          scan_state    = PH_DONE;
        end
      end
      default: ;
    endcase

    // the position with index MaxLen-1 always closes the vector
    if (!mark && pos_count + 1 < MaxLen) begin
      pos_count++;
    end else begin
      produced = 1'b1;
      out_lo   = 0;
      out_hi   = 0;
      if (scan_state == PH_SEEK) begin
        // every position fixed equal: no pivot
        res.pidx = count_t'(pos_count + 1);
        if (reg_detect) st = eff_oe ? ST_HOLDS : ST_NOT_HOLD;
        else st = eff_oe ? ST_ENTAILED : ST_FAILED;
      end else begin
        res.pidx = pivot_at;
        out_lo   = piv_glo;
        out_hi   = piv_lhi;
        n_lo     = (piv_glo > piv_llo) ? piv_glo : piv_llo;
        n_hi     = (piv_lhi < piv_ghi) ? piv_lhi : piv_ghi;
        if (reg_detect) begin
          if (piv_glo > piv_lhi) st = ST_HOLDS;
          else if (piv_ghi < piv_llo) st = ST_NOT_HOLD;
          else st = ST_UNDECIDED;
        end else if (piv_ghi < piv_llo || piv_glo > piv_ghi || piv_llo > piv_lhi) begin
          st = ST_FAILED;
        end else if (n_lo > n_hi) begin
          st = ST_ENTAILED;
          out_lo = n_lo;
          out_hi = n_hi;
        end else if (free_seen || (eff_oe && !blocking_seen)) begin
          st = ST_ACTIVE;
          out_lo = n_lo;
          out_hi = n_hi;
        end else if (!(piv_ghi > piv_llo)) begin
          st = ST_FAILED;
        end else begin
          // strict order forced at the pivot
          s_lo_f = (n_lo > piv_llo + 1) ? n_lo : piv_llo + 1;
          s_hi_f = (n_hi < piv_ghi - 1) ? n_hi : piv_ghi - 1;
          st     = (s_lo_f > s_hi_f) ? ST_ENTAILED : ST_ACTIVE;
          out_lo = s_lo_f;
          out_hi = s_hi_f;
        end
      end
      res.status = st;
      res.lo     = value_t'(out_lo);
      res.hi     = value_t'(out_hi);
      clear_scan();
    end
  endtask

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic directed_row_t mk_row(bit wr, bit oe, bit neg, bit det,
                                           value_t alo, value_t ahi, value_t blo,
                                           value_t bhi, bit last, bit typed,
                                           status_t st, int pidx, value_t lo, value_t hi);
    directed_row_t r;
    r.wr_cfg      = wr;
    r.oe          = oe;
    r.neg         = neg;
    r.det         = det;
    r.alo         = alo;
    r.ahi         = ahi;
    r.blo         = blo;
    r.bhi         = bhi;
    r.last        = last;
    r.typed       = typed;
    r.want.status = st;
    r.want.pidx   = count_t'(pidx);
    r.want.lo     = lo;
    r.want.hi     = hi;
    return r;
  endfunction

  // Append one row to the directed table
  task automatic queue_row(input directed_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // Mostly small values so bounds collide; now and then full-range or extremes
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return value_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return VMIN;
          1: return VMAX;
          2: return VMIN + 1;
          default: return VMAX - 1;
        endcase
      end
      default: return value_t'($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  // Ordered bound pair, left empty now and then
  task automatic pick_pair(output value_t lo, output value_t hi);
    value_t x, y;
    x = pick_value();
    y = pick_value();
    if (x > y && $urandom_range(0, 11) != 0) begin
      lo = y; hi = x;
    end else begin
      lo = x; hi = y;
    end
  endtask

  // Sender pacing: bursts of random length with random gaps, none during a hold-off
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (hold_off_req) gap = 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Offer one position and hold it until the transfer, then predict
  task automatic send_position(input value_t alo, input value_t ahi, input value_t blo,
                               input value_t bhi, input bit last, input bit use_typed,
                               input result_t typed_res);
    bit      produced;
    result_t predicted;
    in_tdata  <= {bhi, blo, ahi, alo};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent_positions++;
    propagate_position(alo, ahi, blo, bhi, last, produced, predicted);
    if (produced)
      expected_verdicts.insert(expected_verdicts.size(),
                               use_typed ? typed_res : predicted);
  endtask

  // Wait until every owed verdict has arrived, then let the pipeline settle
  task automatic drain();
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input bit oe, input bit neg, input bit det);
    in_tvalid <= 1'b0;
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_ALLOW_EQ;
    cfg_wdata <= oe;
    @(posedge clk);
    cfg_addr  <= CFG_NEGATED;
    cfg_wdata <= neg;
    @(posedge clk);
    cfg_addr  <= CFG_DETECT_ONLY;
    cfg_wdata <= det;
    @(posedge clk);
    cfg_we    <= 1'b0;
    reg_allow_eq = oe;
    reg_negated  = neg;
    reg_detect   = det;
  endtask

  // One random vector: a run of fixed-equal positions, a pivot, then positions
  // that are often exactly level so the scan runs on past the pivot.
  task automatic send_vector();
    int     len, fixed_len, pick;
    bit     mark;
    value_t alo, ahi, blo, bhi, v;
    pick = $urandom_range(0, 59);
    if (pick == 0) len = MaxLen;
    else if (pick < 6) len = $urandom_range(9, 20);
    else len = $urandom_range(1, 8);
    // a full-length vector may omit the mark and rely on the length limit
    mark      = (len != MaxLen) || ($urandom_range(0, 1) == 1);
    fixed_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, len);
    for (int p = 0; p < len; p++) begin
      if (p < fixed_len) begin
        v = pick_value();
        alo = v; ahi = v; blo = v; bhi = v;
      end else begin
        pick_pair(alo, ahi);
        pick_pair(blo, bhi);
        if (p > fixed_len && $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 1) == 1) ahi = blo;
          else bhi = alo;
        end
      end
      pace();
      send_position(alo, ahi, blo, bhi, mark && (p == len - 1), 1'b0, '0);
    end
  endtask

  // Check every result transfer against the oldest owed verdict
  always @(posedge clk) begin : check_result
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_verdicts.size() == 0) begin
        note_mismatch($sformatf("result with nothing owed: status %0d pivot %0d",
                                out_tuser, out_tdata[6:0]));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_tuser !== want.status)
          note_mismatch($sformatf("status got %0d want %0d", out_tuser, want.status));
        if (out_tdata[6:0] !== want.pidx)
          note_mismatch($sformatf("pivot_index got %0d want %0d", out_tdata[6:0], want.pidx));
        if (out_tdata[38:7] !== want.lo)
          note_mismatch($sformatf("pivot_new_lo_greater got %0d want %0d",
                                  $signed(out_tdata[38:7]), want.lo));
        if (out_tdata[70:39] !== want.hi)
          note_mismatch($sformatf("pivot_new_hi_lesser got %0d want %0d",
                                  $signed(out_tdata[70:39]), want.hi));
      end
    end
  end

  // Watchdog: count cycles without any transfer on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("tb_lex_order_bounds_propagator failed");
      $finish;
    end
  end

  // Receiver: rotate through stall patterns; on request hold
  // off completely for a long stretch so the block backs up into its input.
  initial begin : receiver
    int rx_cycle;
    rx_cycle = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        rx_cycle++;
        case (rx_cycle[7:6])
          2'd0: out_tready <= 1'b1;
          2'd1: out_tready <= ($urandom_range(0, 1) == 1);
          2'd2: out_tready <= (rx_cycle[1:0] == 2'd0);
          default: out_tready <= ($urandom_range(0, 6) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int target;
    mismatches     = 0;
    sent_positions = 0;
    burst_left     = 0;
    quiet_cycles   = 0;
    hold_off_req   = 1'b0;
    reg_allow_eq   = 1'b1;
    reg_negated    = 1'b0;
    reg_detect     = 1'b0;
    clear_scan();

    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_ALLOW_EQ;
    cfg_wdata <= 1'b0;
    rst_n     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n     <= 1'b1;

    // Directed part. Columns: config write and its values, first bounds, second
    // bounds, mark, typed verdict and its status, pivot, lower and upper bound.
    // default settings: no pivot, extremes, crossed bounds, empty interval, entailed
    queue_row(mk_row(1, 1, 0, 0, 5, 5, 5, 5, 1, 1, ST_ENTAILED, 1, 0, 0));
    queue_row(mk_row(0, 0, 0, 0, VMIN, VMAX, VMIN, VMAX, 1, 1,
                     ST_ACTIVE, 0, VMIN, VMAX));
    queue_row(mk_row(0, 0, 0, 0, 0, 0, 1, 1, 1, 1, ST_FAILED, 0, 0, 1));
    queue_row(mk_row(0, 0, 0, 0, 5, 3, 0, 1, 1, 1, ST_FAILED, 0, 5, 1));
    queue_row(mk_row(0, 0, 0, 0, 10, 20, 0, 5, 1, 1, ST_ENTAILED, 0, 10, 5));
    // pivot after an equal prefix, blocking position after it
    queue_row(mk_row(0, 0, 0, 0, 7, 7, 7, 7, 0, 0, ST_ACTIVE, 0, 0, 0));
    queue_row(mk_row(0, 0, 0, 0, 0, 10, 0, 10, 0, 0, ST_ACTIVE, 0, 0, 0));
    queue_row(mk_row(0, 0, 0, 0, 0, 0, 5, 5, 1, 0, ST_ACTIVE, 0, 0, 0));
    // free position after the pivot
    queue_row(mk_row(0, 0, 0, 0, 0, 10, 0, 10, 0, 0, ST_ACTIVE, 0, 0, 0));
    queue_row(mk_row(0, 0, 0, 0, 0, 10, 0, 0, 1, 0, ST_ACTIVE, 0, 0, 0));
    // strict order demanded
    queue_row(mk_row(1, 0, 0, 0, 5, 5, 5, 5, 1, 1, ST_FAILED, 1, 0, 0));
    queue_row(mk_row(0, 0, 0, 0, 0, 5, 5, 9, 1, 0, ST_ACTIVE, 0, 0, 0));
    queue_row(mk_row(0, 0, 0, 0, VMIN, VMAX, VMIN, VMAX, 1, 1,
                     ST_ACTIVE, 0, VMIN + 1, VMAX - 1));
    // negation swaps the sides and flips or-equal
    queue_row(mk_row(1, 0, 1, 0, 0, 0, 1, 1, 1, 1, ST_ENTAILED, 0, 1, 0));
    // detect mode, negated
    queue_row(mk_row(1, 0, 1, 1, 3, 3, 3, 3, 1, 1, ST_HOLDS, 1, 0, 0));
    queue_row(mk_row(0, 0, 0, 0, 0, 5, 0, 5, 1, 0, ST_ACTIVE, 0, 0, 0));
    queue_row(mk_row(0, 0, 0, 0, 9, 9, 0, 1, 1, 1, ST_NOT_HOLD, 0, 0, 9));
    queue_row(mk_row(1, 1, 1, 1, 3, 3, 3, 3, 1, 1, ST_NOT_HOLD, 1, 0, 0));
    queue_row(mk_row(0, 0, 0, 0, 0, 0, 3, 3, 1, 1, ST_HOLDS, 0, 3, 0));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].wr_cfg)
        write_config(directed_rows[i].oe, directed_rows[i].neg, directed_rows[i].det);
      pace();
      send_position(directed_rows[i].alo, directed_rows[i].ahi, directed_rows[i].blo,
                    directed_rows[i].bhi, directed_rows[i].last, directed_rows[i].typed,
                    directed_rows[i].want);
    end

    // Random part: one phase per setting of the three registers, each entered
    // from idle. Two phases open with a long receiver hold-off.
    for (int ph = 0; ph < 8; ph++) begin
      write_config(ph[0], ph[1], ph[2]);
      if (ph == 1 || ph == 5) hold_off_req = 1'b1;
      target = sent_positions + PHASE_POSITIONS;
      while (sent_positions < target) send_vector();
    end

    in_tvalid <= 1'b0;
    drain();
    if (mismatches == 0) $display("tb_lex_order_bounds_propagator passed");
    else $display("tb_lex_order_bounds_propagator failed");
    $finish;
  end

endmodule
